>>> hw/rtl/ctgf_pkg.sv
package ctgf_pkg;

    // Grid size
    localparam int MAX_COLS = 32;
    localparam int MAX_ROWS = 32;
    localparam int GRID_N   = MAX_ROWS * MAX_COLS;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Configuration register width
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    // Common width for address and bound compares
    localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W  = $clog2(MAX_COLS + 1);
    localparam int CMPA_W  = (RCNT_W > CCNT_W) ? RCNT_W : CCNT_W;
    localparam int CMPB_W  = (CMPA_W > CFG_W) ? CMPA_W : CFG_W;
    localparam int CMP_W   = (CMPB_W > 5) ? CMPB_W : 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd1;

    // Operation codes
    localparam logic [2:0] MODE_WRITE  = 3'd0;
    localparam logic [2:0] MODE_MARK   = 3'd1;
    localparam logic [2:0] MODE_UNMARK = 3'd2;
    localparam logic [2:0] MODE_READ   = 3'd3;
    localparam logic [2:0] MODE_FIND   = 3'd4;
    localparam logic [2:0] MODE_CLEAR  = 3'd5;

    // Colour codes
    localparam logic [2:0] COLOR_RED    = 3'd0;
    localparam logic [2:0] COLOR_YELLOW = 3'd1;
    localparam logic [2:0] COLOR_GREEN  = 3'd2;
    localparam logic [2:0] COLOR_BLUE   = 3'd3;
    localparam logic [2:0] COLOR_EMPTY  = 3'd4;

    // Hue band limits in degrees
    localparam logic [8:0] BAND_YELLOW = 9'd40;
    localparam logic [8:0] BAND_GREEN  = 9'd80;
    localparam logic [8:0] BAND_BLUE   = 9'd170;
    localparam logic [8:0] BAND_TOP    = 9'd280;

    typedef struct packed {
        logic [2:0] color;
        logic       drawn;
    } tag_t;

    localparam tag_t TAG_EMPTY = '{color: COLOR_EMPTY, drawn: 1'b0};

    typedef struct packed {
        logic [2:0] mode;
        logic [4:0] col_index;
        logic [4:0] row_index;
        logic [7:0] hue;
        logic [2:0] query_color;
        logic       query_drawn;
    } cmd_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] tag_color;
        logic       tag_drawn;
        logic [4:0] found_row;
        logic [4:0] found_col;
    } result_t;

    // Scan position and phase handed to the head unit
    typedef struct packed {
        logic             init;
        logic             scan;
        logic             first;
        logic             in_use;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } head_ctl_t;

    function automatic logic [2:0] classify_hue(input logic [7:0] hue);
        logic [8:0] deg;
        deg = {hue, 1'b0};
        if (deg < BAND_YELLOW)
            return COLOR_RED;
        else if (deg < BAND_GREEN)
            return COLOR_YELLOW;
        else if (deg < BAND_BLUE)
            return COLOR_GREEN;
        else if (deg < BAND_TOP)
            return COLOR_BLUE;
        else
            return COLOR_RED;
    endfunction

endpackage

>>> hw/rtl/color_tag_grid_with_first_match_unit.sv
// Colour tag grid with first-match search.
//
// Command channel: drive cmd and raise start; the command transfers at a
// rising edge where start is high and busy is low. Each command gives one
// result: done is high for exactly one cycle with result valid in that same
// cycle. The receiver cannot hold a result off; take it when done is high.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 is grid_cols, index 1 is grid_rows. cfg_ready is always high.
// Write configuration only while busy is low and no result is pending.
//
// Operation: every command rotates the whole tag ring once past the head
// unit, one entry per cycle, so busy stays high for the whole lap after the
// transfer and done is shown in the cycle after the lap ends. The ring
// rotation sets the rate: a new command may transfer at the edge that ends
// the done cycle; the block takes no new command while one is in its lap.
// Reset: the registers return to 32 by 32 and the ring is swept once to
// empty, undrawn tags; busy stays high for the whole sweep.
module color_tag_grid_with_first_match_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ctgf_pkg::cmd_t                   cmd,
    output logic                             done,
    output ctgf_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ctgf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ctgf_pkg::CFG_W-1:0]       cfg_data
);
    import ctgf_pkg::*;

    // Sequencer states
    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             done_reg;
    logic             done_next;
    logic [CFG_W-1:0] grid_cols_reg;
    logic [CFG_W-1:0] grid_rows_reg;
    cmd_t             cmd_reg;

    logic             shift;
    logic             last;
    logic             accept;
    logic [CMP_W-1:0] used_cols;
    logic [CMP_W-1:0] used_rows;
    head_ctl_t        ctl;
    tag_t             head_tag;
    tag_t             ring [GRID_N];

    // ---------------------------------------------------------------
    // Configuration registers: always ready, one transfer per cycle
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= CFG_W'(32);
            grid_rows_reg <= CFG_W'(32);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GRID_COLS: grid_cols_reg <= cfg_data;
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                default:       grid_cols_reg <= grid_cols_reg;
            endcase
        end
    end

    // Saturate the registers to the physical grid
    assign used_cols = (CMP_W'(grid_cols_reg) > CMP_W'(MAX_COLS))
                       ? CMP_W'(MAX_COLS) : CMP_W'(grid_cols_reg);
    assign used_rows = (CMP_W'(grid_rows_reg) > CMP_W'(MAX_ROWS))
                       ? CMP_W'(MAX_ROWS) : CMP_W'(grid_rows_reg);

    // ---------------------------------------------------------------
    // Sequencer: sweep after reset, then one full lap per command
    // ---------------------------------------------------------------
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign shift  = (state_reg == ST_INIT) || (state_reg == ST_SCAN);
    assign last   = (row_reg == ROW_LAST) && (col_reg == COL_LAST);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                if (last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Advance the row-major position of the entry at the head;
    // a full lap brings both counters back to zero
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (shift)
        begin
            if (col_reg == COL_LAST)
            begin
                col_next = '0;
                row_next = (row_reg == ROW_LAST) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            row_reg   <= '0;
            col_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            done_reg  <= done_next;
        end
    end

    // Hold the command for the whole lap
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

    // ---------------------------------------------------------------
    // Head unit: edits the entry leaving the ring and builds the result
    // ---------------------------------------------------------------
    assign ctl.init   = (state_reg == ST_INIT);
    assign ctl.scan   = (state_reg == ST_SCAN);
    assign ctl.first  = (row_reg == '0) && (col_reg == '0);
    assign ctl.in_use = (CMP_W'(row_reg) < used_rows) && (CMP_W'(col_reg) < used_cols);
    assign ctl.row    = row_reg;
    assign ctl.col    = col_reg;

    ctgf_head u_head (
        .clk     (clk),
        .ctl     (ctl),
        .cmd     (cmd_reg),
        .tag_in  (ring[GRID_N-1]),
        .tag_out (head_tag),
        .result  (result)
    );

    // ---------------------------------------------------------------
    // Tag ring: entry e sits in the last cell when the lap position is e;
    // the edited tag re-enters at the first cell
    // ---------------------------------------------------------------
    for (genvar i = 0; i < GRID_N; i++)
    begin : g_ring
        if (i == 0)
        begin : g_first
            ctgf_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (head_tag),
                .q     (ring[i])
            );
        end
        else
        begin : g_rest
            ctgf_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (ring[i-1]),
                .q     (ring[i])
            );
        end
    end

    assign done = done_reg;

endmodule

>>> hw/rtl/ctgf_cell.sv
module ctgf_cell (
    input  logic           clk,
    input  logic           shift,
    input  ctgf_pkg::tag_t d,
    output ctgf_pkg::tag_t q
);
    import ctgf_pkg::*;

    tag_t tag_reg;

    // Take the neighbour's tag while the ring advances, hold otherwise
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            tag_reg <= d;
        end
    end

    assign q = tag_reg;

endmodule

>>> hw/rtl/ctgf_head.sv
module ctgf_head (
    input  logic                clk,
    input  ctgf_pkg::head_ctl_t ctl,
    input  ctgf_pkg::cmd_t      cmd,
    input  ctgf_pkg::tag_t      tag_in,
    output ctgf_pkg::tag_t      tag_out,
    output ctgf_pkg::result_t   result
);
    import ctgf_pkg::*;

    result_t result_reg;
    result_t result_next;
    result_t base;
    logic    hit;
    logic    known;

    assign hit = ctl.in_use
                 && (CMP_W'(cmd.row_index) == CMP_W'(ctl.row))
                 && (CMP_W'(cmd.col_index) == CMP_W'(ctl.col));
    assign known = (tag_in.color < COLOR_EMPTY);

    always_comb
    begin
        // Drop the previous result at the first entry of a lap
        if (ctl.first)
        begin
            base.ok        = (cmd.mode == MODE_CLEAR);
            base.tag_color = COLOR_EMPTY;
            base.tag_drawn = 1'b0;
            base.found_row = 5'd0;
            base.found_col = 5'd0;
        end
        else
        begin
            base = result_reg;
        end

        result_next = base;
        tag_out     = tag_in;

        if (ctl.init)
        begin
            tag_out = TAG_EMPTY;
        end
        else if (ctl.scan)
        begin
            case (cmd.mode)
                MODE_WRITE:
                begin
                    if (hit)
                    begin
                        tag_out.color  = classify_hue(cmd.hue);
                        tag_out.drawn  = 1'b0;
                        result_next.ok = 1'b1;
                    end
                end
                MODE_MARK:
                begin
                    if (hit && known && !tag_in.drawn)
                    begin
                        tag_out.drawn  = 1'b1;
                        result_next.ok = 1'b1;
                    end
                end
                MODE_UNMARK:
                begin
                    if (hit && known && tag_in.drawn)
                    begin
                        tag_out.drawn  = 1'b0;
                        result_next.ok = 1'b1;
                    end
                end
                MODE_READ:
                begin
                    if (hit)
                    begin
                        result_next.ok        = 1'b1;
                        result_next.tag_color = tag_in.color;
                        result_next.tag_drawn = tag_in.drawn;
                    end
                end
                MODE_FIND:
                begin
                    if (ctl.in_use && !base.ok
                        && (tag_in.color == cmd.query_color)
                        && (tag_in.drawn == cmd.query_drawn))
                    begin
                        result_next.ok        = 1'b1;
                        result_next.found_row = 5'(ctl.row);
                        result_next.found_col = 5'(ctl.col);
                    end
                end
                MODE_CLEAR:
                begin
                    if (ctl.in_use)
                    begin
                        tag_out.drawn = 1'b0;
                    end
                end
                default:
                begin
                    result_next = base;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.scan)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> hw/rtl/ctgf_checker.sv
module ctgf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input ctgf_pkg::result_t              result
);
    import ctgf_pkg::*;

    // A transferred command keeps the block busy for its lap
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    // The result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done high for more than one cycle");

    // A result is never shown right after a transfer
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(start && !busy))
        else $error("result shown one cycle after transfer");

    // The block is free again while a result is shown
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while result shown");

    // A failed operation carries only default fields
    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ok) |-> (result.tag_color == COLOR_EMPTY)
            && !result.tag_drawn && (result.found_row == 5'd0)
            && (result.found_col == 5'd0))
        else $error("failed result carries non-default fields");

endmodule

bind color_tag_grid_with_first_match_unit ctgf_checker u_ctgf_checker (.*);

>>> bench/grid_tag_checker.sv
module grid_tag_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  ctgf_pkg::cmd_t                  cmd,
    input  logic                            done,
    input  ctgf_pkg::result_t               result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [ctgf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctgf_pkg::CFG_W-1:0]      cfg_data,
    output int                              mismatches,
    output int                              outstanding
);
    import ctgf_pkg::*;

    tag_t             tag_grid [MAX_ROWS][MAX_COLS];
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;
    result_t          pending_results [$];

    function automatic int span(input logic [CFG_W-1:0] setting, input int limit);
        return (setting > limit) ? limit : int'(setting);
    endfunction

    function automatic logic [2:0] hue_colour(input logic [7:0] hue);
        logic [8:0] deg;
        deg = {hue, 1'b0};
        if (deg >= BAND_TOP || deg < BAND_YELLOW)
            return COLOR_RED;
        if (deg < BAND_GREEN)
            return COLOR_YELLOW;
        if (deg < BAND_BLUE)
            return COLOR_GREEN;
        return COLOR_BLUE;
    endfunction

    // Apply one command to the grid copy and return the result it must give.
    function automatic result_t apply_grid_op(input cmd_t c);
        result_t res;
        int      ncols;
        int      nrows;
        logic    in_range;
        tag_t    cur;
        ncols    = span(cols_reg, MAX_COLS);
        nrows    = span(rows_reg, MAX_ROWS);
        in_range = (int'(c.col_index) < ncols) && (int'(c.row_index) < nrows);
        cur      = tag_grid[c.row_index][c.col_index];
        res      = '{ok: 1'b0, tag_color: COLOR_EMPTY, tag_drawn: 1'b0,
                     found_row: 5'd0, found_col: 5'd0};
        case (c.mode)
            MODE_WRITE:
                if (in_range)
                begin
                    tag_grid[c.row_index][c.col_index] = '{color: hue_colour(c.hue),
                                                           drawn: 1'b0};
                    res.ok = 1'b1;
                end
            MODE_MARK:
                if (in_range && cur.color != COLOR_EMPTY && !cur.drawn)
                begin
                    tag_grid[c.row_index][c.col_index].drawn = 1'b1;
                    res.ok = 1'b1;
                end
            MODE_UNMARK:
                if (in_range && cur.color != COLOR_EMPTY && cur.drawn)
                begin
                    tag_grid[c.row_index][c.col_index].drawn = 1'b0;
                    res.ok = 1'b1;
                end
            MODE_READ:
                if (in_range)
                begin
                    res.ok        = 1'b1;
                    res.tag_color = cur.color;
                    res.tag_drawn = cur.drawn;
                end
            MODE_FIND:
                for (int r = 0; r < nrows; r++)
                begin
                    for (int k = 0; k < ncols; k++)
                    begin
                        if (!res.ok && tag_grid[r][k].color == c.query_color
                            && tag_grid[r][k].drawn == c.query_drawn)
                        begin
                            res.ok        = 1'b1;
                            res.found_row = 5'(r);
                            res.found_col = 5'(k);
                        end
                    end
                end
            MODE_CLEAR:
            begin
                for (int r = 0; r < nrows; r++)
                begin
                    for (int k = 0; k < ncols; k++)
                        tag_grid[r][k].drawn = 1'b0;
                end
                res.ok = 1'b1;
            end
            default:
                ;
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [4:0] want,
                               input logic [4:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_ROWS; r++)
            begin
                for (int k = 0; k < MAX_COLS; k++)
                    tag_grid[r][k] = TAG_EMPTY;
            end
            cols_reg = CFG_W'(MAX_COLS);
            rows_reg = CFG_W'(MAX_ROWS);
            pending_results.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GRID_COLS)
                    cols_reg = cfg_data;
                else if (cfg_index == REG_GRID_ROWS)
                    rows_reg = cfg_data;
            end
            // Retire the older command before a new one that transfers at this edge.
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("ok",        5'(want.ok),        5'(result.ok));
                    check_field("tag_color", 5'(want.tag_color), 5'(result.tag_color));
                    check_field("tag_drawn", 5'(want.tag_drawn), 5'(result.tag_drawn));
                    check_field("found_row", want.found_row,     result.found_row);
                    check_field("found_col", want.found_col,     result.found_col);
                end
            end
            if (start && !busy)
                pending_results.push_back(apply_grid_op(cmd));
            outstanding <= pending_results.size();
        end
    end

endmodule

>>> bench/testbench.sv
module testbench;
    import ctgf_pkg::*;

    // Modes with no operation behind them, and a find colour that never matches
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam logic [2:0] QUERY_VOID   = 3'd7;

    // One command walks the whole ring, so allow a full pass plus margin
    localparam int DRAIN_CYCLES = GRID_N + 64;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 70;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    cmd_t                 cmd       = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 busy;
    logic                 done;
    logic                 cfg_ready;
    result_t              result;
    int                   mismatches;
    int                   outstanding;

    // Grid size last written, used to steer addresses near the edge
    int                   cols_set = MAX_COLS;
    int                   rows_set = MAX_ROWS;
    bit                   idle_en;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    color_tag_grid_with_first_match_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    grid_tag_checker tag_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic cmd_t make_cmd(input logic [2:0] mode, input logic [4:0] row,
                                      input logic [4:0] col, input logic [7:0] hue,
                                      input logic [2:0] qcolour, input logic qdrawn);
        return '{mode: mode, col_index: col, row_index: row, hue: hue,
                 query_color: qcolour, query_drawn: qdrawn};
    endfunction

    // Pick an address mostly inside the grid or just past its edge, now and then anywhere.
    function automatic logic [4:0] pick_index(input int in_use);
        int lim;
        lim = (in_use > 31) ? 31 : in_use;
        if ($urandom_range(0, 6) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, lim));
    endfunction

    // Random command, weighted across the modes.
    function automatic cmd_t random_cmd();
        int         pick;
        logic [2:0] mode;
        logic [2:0] qcolour;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            mode = MODE_WRITE;
        else if (pick < 45)
            mode = MODE_MARK;
        else if (pick < 60)
            mode = MODE_UNMARK;
        else if (pick < 75)
            mode = MODE_READ;
        else if (pick < 88)
            mode = MODE_FIND;
        else if (pick < 94)
            mode = MODE_CLEAR;
        else
            mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE_A : MODE_SPARE_B;
        if ($urandom_range(0, 9) == 0)
            qcolour = 3'($urandom_range(int'(COLOR_EMPTY) + 1, int'(QUERY_VOID)));
        else
            qcolour = 3'($urandom_range(int'(COLOR_RED), int'(COLOR_EMPTY)));
        return make_cmd(mode,
                        pick_index((rows_set > MAX_ROWS) ? MAX_ROWS : rows_set),
                        pick_index((cols_set > MAX_COLS) ? MAX_COLS : cols_set),
                        8'($urandom_range(0, 255)), qcolour, 1'($urandom_range(0, 1)));
    endfunction

    // Offer one command and hold it until it transfers. Start is left high so the
    // next command can follow back to back; an idle burst drops it first.
    task automatic issue(input cmd_t c);
        logic [31:0] junk;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            junk = $urandom;
            start <= 1'b0;
            cmd   <= junk[$bits(cmd_t)-1:0];
            // Half the bursts start only once the block has come free
            if ($urandom_range(0, 1) == 0)
            begin
                @(posedge clk);
                while (busy)
                    @(posedge clk);
            end
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and wait until the block is free and every result is back.
    task automatic await_idle();
        start <= 1'b0;
        @(posedge clk);
        while (busy || outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_grid(input int ncols, input int nrows);
        await_idle();
        write_reg(REG_GRID_COLS, CFG_W'(ncols));
        write_reg(REG_GRID_ROWS, CFG_W'(nrows));
        cfg_valid <= 1'b0;
        cols_set = ncols;
        rows_set = nrows;
    endtask

    // Hues on both sides of every band limit, plus the field extremes
    int hue_edges [10] = '{0, 19, 20, 39, 40, 84, 85, 139, 140, 255};
    // Grid sizes per random phase; -1 asks for a small random size
    int phase_cols [PHASES] = '{32, 1, 4, 0, 32, 1, 63, -1};
    int phase_rows [PHASES] = '{32, 1, 3, 32, 1, 32, 7, -1};

    initial
    begin
        int ncols;
        int nrows;
        idle_en = 1'b1;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: the grid starts out empty and undrawn
        issue(make_cmd(MODE_READ, 5'd0, 5'd0, 8'd0, COLOR_RED, 1'b0));
        issue(make_cmd(MODE_FIND, 5'd0, 5'd0, 8'd0, COLOR_EMPTY, 1'b0));
        // Band edges along row 0; the top hue goes to the far corner
        for (int i = 0; i < 10; i++)
        begin
            if (i == 9)
                issue(make_cmd(MODE_WRITE, 5'd31, 5'd31, 8'(hue_edges[i]),
                               COLOR_RED, 1'b0));
            else
                issue(make_cmd(MODE_WRITE, 5'd0, 5'(i), 8'(hue_edges[i]),
                               COLOR_RED, 1'b0));
        end
        issue(make_cmd(MODE_READ, 5'd31, 5'd31, 8'd0, COLOR_RED, 1'b0));
        // Mark a yellow entry, then try it again and on an empty entry
        issue(make_cmd(MODE_MARK, 5'd0, 5'd2, 8'd0, COLOR_RED, 1'b0));
        issue(make_cmd(MODE_MARK, 5'd0, 5'd2, 8'd0, COLOR_RED, 1'b0));
        issue(make_cmd(MODE_MARK, 5'd5, 5'd5, 8'd0, COLOR_RED, 1'b0));
        issue(make_cmd(MODE_FIND, 5'd0, 5'd0, 8'd0, COLOR_YELLOW, 1'b1));
        issue(make_cmd(MODE_FIND, 5'd0, 5'd0, 8'd0, COLOR_BLUE, 1'b0));
        // An empty entry can never carry a drawn mark
        issue(make_cmd(MODE_FIND, 5'd0, 5'd0, 8'd0, COLOR_EMPTY, 1'b1));
        issue(make_cmd(MODE_UNMARK, 5'd0, 5'd2, 8'd0, COLOR_RED, 1'b0));
        issue(make_cmd(MODE_CLEAR, 5'd0, 5'd0, 8'd0, COLOR_RED, 1'b0));
        issue(make_cmd(MODE_SPARE_A, 5'd0, 5'd0, 8'd0, COLOR_RED, 1'b0));
        // Leave a mark outside a small grid; clearing the small grid must keep it
        issue(make_cmd(MODE_MARK, 5'd31, 5'd31, 8'd0, COLOR_RED, 1'b0));
        set_grid(2, 2);
        issue(make_cmd(MODE_CLEAR, 5'd0, 5'd0, 8'd0, COLOR_RED, 1'b0));
        issue(make_cmd(MODE_WRITE, 5'd0, 5'd2, 8'd100, COLOR_RED, 1'b0));
        issue(make_cmd(MODE_READ, 5'd2, 5'd0, 8'd0, COLOR_RED, 1'b0));
        // Register values past the maximum saturate to the full grid
        set_grid(63, 63);
        issue(make_cmd(MODE_READ, 5'd31, 5'd31, 8'd0, COLOR_RED, 1'b0));
        // Zero columns: nothing is in range and find never matches
        set_grid(0, 1);
        issue(make_cmd(MODE_FIND, 5'd0, 5'd0, 8'd0, COLOR_EMPTY, 1'b0));
        issue(make_cmd(MODE_WRITE, 5'd0, 5'd0, 8'd0, COLOR_RED, 1'b0));

        // Random phases, each under its own grid size; no idling in the last one
        for (int p = 0; p < PHASES; p++)
        begin
            ncols = (phase_cols[p] < 0) ? $urandom_range(1, 8) : phase_cols[p];
            nrows = (phase_rows[p] < 0) ? $urandom_range(1, 8) : phase_rows[p];
            set_grid(ncols, nrows);
            idle_en = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS)
                issue(random_cmd());
        end

        // Drain: every result back, then a full pass for anything unexpected
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop, several times the slowest correct run
    initial
    begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
